[rtl/fps_pkg.sv]
`default_nettype none

package fps_pkg;

  localparam int unsigned SLOT_MAX      = 16;
  localparam int unsigned SLOT_W        = 4;
  localparam int unsigned BLK_W         = 128;
  localparam int unsigned DEF_SLOTS     = 16;
  localparam int unsigned DEF_BLOCKS    = 64;
  localparam int unsigned DEF_TOY_BLOCK = 1;

  localparam logic [7:0] RDY_B1   = 8'h02;
  localparam logic [7:0] RDY_B2   = 8'h18;
  localparam logic [7:0] ACT_B2   = 8'hFF;
  localparam logic [7:0] ACT_PLO  = 8'h77;
  localparam logic [7:0] QRY_HIT  = 8'h10;
  localparam logic [7:0] QRY_ERR  = 8'h01;
  localparam logic [7:0] STS_MARK = 8'h01;
  localparam logic [3:0] SLOT_MSK = 4'h0F;

  typedef enum logic [3:0] {
    KIND_READY       = 4'd0,
    KIND_ACTIVATE    = 4'd1,
    KIND_COLOR       = 4'd2,
    KIND_QUERY       = 4'd3,
    KIND_WRITE       = 4'd4,
    KIND_STATUS_TICK = 4'd5,
    KIND_SET_PRESENT = 4'd6,
    KIND_LOAD_BLOCK  = 4'd7,
    KIND_CLEAR       = 4'd8,
    KIND_SYNC        = 4'd9,
    KIND_READ_STATE  = 4'd10
  } kind_e;

  typedef enum logic [2:0] {
    RESP_READY    = 3'd0,
    RESP_ACTIVATE = 3'd1,
    RESP_COLOR    = 3'd2,
    RESP_QUERY    = 3'd3,
    RESP_WRITE    = 3'd4,
    RESP_STATUS   = 3'd5,
    RESP_STATE    = 3'd6
  } resp_e;

  typedef struct packed {
    logic              set_toy;
    logic              mark;
    logic              drop;
    logic              sync;
    logic              set_active;
    logic              active_val;
    logic              count_inc;
    logic [SLOT_W-1:0] slot;
    logic [15:0]       toy;
    logic [15:0]       keep;
  } meta_cmd_t;

  typedef struct packed {
    logic [SLOT_MAX-1:0] present;
    logic                active;
    logic [7:0]          count;
    logic [15:0]         current_toy;
  } meta_stat_t;

endpackage

`default_nettype wire

[rtl/fps_mem.sv]
`default_nettype none

module fps_mem #(
  parameter int unsigned DEPTH  = 1024,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                      clk_i,
  input  wire logic                      we_i,
  input  wire logic [ADDR_W-1:0]         waddr_i,
  input  wire logic [fps_pkg::BLK_W-1:0] wdata_i,
  input  wire logic                      re_i,
  input  wire logic [ADDR_W-1:0]         raddr_i,
  output logic      [fps_pkg::BLK_W-1:0] rdata_o
);
  import fps_pkg::*;

  logic [BLK_W-1:0] mem [DEPTH];
  logic [BLK_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[rtl/fps_meta.sv]
`default_nettype none

module fps_meta (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire fps_pkg::meta_cmd_t  cmd_i,
  output fps_pkg::meta_stat_t      stat_o
);
  import fps_pkg::*;

  logic [SLOT_MAX-1:0] present_q, present_d;
  logic [15:0]         toy_q [SLOT_MAX];
  logic [15:0]         toy_d [SLOT_MAX];
  logic                active_q, active_d;
  logic [7:0]          count_q, count_d;
  logic [15:0]         cur_toy;

  always_comb begin
    present_d = present_q;
    toy_d     = toy_q;
    active_d  = active_q;
    count_d   = count_q;
    if (cmd_i.set_toy) begin
      toy_d[cmd_i.slot]     = cmd_i.toy;
      present_d[cmd_i.slot] = 1'b1;
    end
    if (cmd_i.mark) begin
      present_d[cmd_i.slot] = 1'b1;
    end
    if (cmd_i.drop) begin
      toy_d[cmd_i.slot]     = '0;
      present_d[cmd_i.slot] = 1'b0;
    end
    if (cmd_i.sync) begin
      for (int i = 0; i < SLOT_MAX; i++) begin
        if (!cmd_i.keep[i] && present_q[i]) begin
          toy_d[i] = '0;
        end
      end
      present_d = present_q & cmd_i.keep;
    end
    if (cmd_i.set_active) begin
      active_d = cmd_i.active_val;
    end
    if (cmd_i.count_inc) begin
      count_d = count_q + 8'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      present_q <= '0;
      active_q  <= 1'b0;
      count_q   <= '0;
      for (int i = 0; i < SLOT_MAX; i++) begin
        toy_q[i] <= '0;
      end
    end else begin
      present_q <= present_d;
      active_q  <= active_d;
      count_q   <= count_d;
      toy_q     <= toy_d;
    end
  end

  // lowest present slot wins
  always_comb begin
    cur_toy = '0;
    for (int i = SLOT_MAX - 1; i >= 0; i--) begin
      if (present_q[i]) begin
        cur_toy = toy_q[i];
      end
    end
  end

  assign stat_o.present     = present_q;
  assign stat_o.active      = active_q;
  assign stat_o.count       = count_q;
  assign stat_o.current_toy = cur_toy;

endmodule

`default_nettype wire

[rtl/fps_ctrl.sv]
`default_nettype none

module fps_ctrl #(
  parameter int unsigned SLOTS     = 16,
  parameter int unsigned BLOCKS    = 64,
  parameter int unsigned TOY_BLOCK = 1,
  parameter int unsigned DEPTH     = SLOTS * BLOCKS,
  parameter int unsigned ADDR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic [3:0]                 kind_i,
  input  wire logic [fps_pkg::SLOT_W-1:0] slot_i,
  input  wire logic [7:0]                 block_i,
  input  wire logic [7:0]                 byte_a_i,
  input  wire logic [7:0]                 byte_b_i,
  input  wire logic [7:0]                 byte_c_i,
  input  wire logic                       arg_present_i,
  input  wire logic [63:0]                data_lo_i,
  input  wire logic [63:0]                data_hi_i,
  input  wire logic [15:0]                toy_id_i,
  input  wire logic [15:0]                keep_mask_i,
  output logic                            done_o,
  output logic [2:0]                      resp_kind_o,
  output logic [7:0]                      byte1_o,
  output logic [7:0]                      byte2_o,
  output logic [63:0]                     payload_lo_o,
  output logic [63:0]                     payload_hi_o,
  output logic                            mem_we_o,
  output logic [ADDR_W-1:0]               mem_waddr_o,
  output logic [fps_pkg::BLK_W-1:0]       mem_wdata_o,
  output logic                            mem_re_o,
  output logic [ADDR_W-1:0]               mem_raddr_o,
  input  wire logic [fps_pkg::BLK_W-1:0]  mem_rdata_i,
  output fps_pkg::meta_cmd_t              meta_cmd_o,
  input  wire fps_pkg::meta_stat_t        meta_stat_i
);
  import fps_pkg::*;

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_EXEC  = 2'd2;

  localparam logic        TOY_OK = (TOY_BLOCK < BLOCKS);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

  logic [1:0]         state_q, state_d;
  logic [ADDR_W-1:0]  clr_q, clr_d;
  logic               accept;
  logic               slot_ok, blk_ok, addr_ok;
  logic [ADDR_W-1:0]  addr;

  logic [3:0]         kind_q;
  logic [SLOT_W-1:0]  slot_q;
  logic [7:0]         block_q, ba_q, bb_q, bc_q;
  logic               arg_q, slot_ok_q, addr_ok_q;
  logic [63:0]        dlo_q, dhi_q;
  logic [15:0]        toy_q, keep_q;
  logic [ADDR_W-1:0]  addr_q;

  logic               emit;
  logic [2:0]         rk;
  logic [7:0]         b1, b2;
  logic [63:0]        plo, phi;
  logic               wr_en;
  logic [BLK_W-1:0]   wr_data;
  logic               act_new;
  logic               hit;
  logic [31:0]        packed_bits;
  meta_cmd_t          mcmd;

  logic               done_q;
  logic [2:0]         rk_q;
  logic [7:0]         b1_q, b2_q;
  logic [63:0]        plo_q, phi_q;

  assign accept  = start && (state_q == ST_IDLE);
  assign slot_ok = ({1'b0, slot_i} < 5'(SLOTS));
  assign blk_ok  = ({1'b0, block_i} < 9'(BLOCKS));

  always_comb begin
    if (kind_i == KIND_SET_PRESENT) begin
      addr    = ADDR_W'(slot_i) * ADDR_W'(BLOCKS) + ADDR_W'(TOY_BLOCK);
      addr_ok = slot_ok && TOY_OK;
    end else begin
      addr    = ADDR_W'(slot_i) * ADDR_W'(BLOCKS) + ADDR_W'(block_i);
      addr_ok = slot_ok && blk_ok;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q    <= kind_i;
      slot_q    <= slot_i & SLOT_MSK;
      block_q   <= block_i;
      ba_q      <= byte_a_i;
      bb_q      <= byte_b_i;
      bc_q      <= byte_c_i;
      arg_q     <= arg_present_i;
      dlo_q     <= data_lo_i;
      dhi_q     <= data_hi_i;
      toy_q     <= toy_id_i;
      keep_q    <= keep_mask_i;
      slot_ok_q <= slot_ok;
      addr_ok_q <= addr_ok;
      addr_q    <= addr;
    end
  end

  assign mem_re_o    = accept && addr_ok;
  assign mem_raddr_o = addr;

  always_comb begin
    for (int i = 0; i < SLOT_MAX; i++) begin
      packed_bits[2*i]   = meta_stat_i.present[i];
      packed_bits[2*i+1] = 1'b0;
    end
  end

  assign act_new = arg_q && (ba_q != 8'd0);
  assign hit     = addr_ok_q && meta_stat_i.present[slot_q];

  always_comb begin
    emit    = 1'b0;
    rk      = RESP_READY;
    b1      = '0;
    b2      = '0;
    plo     = '0;
    phi     = '0;
    wr_en   = 1'b0;
    wr_data = {dhi_q, dlo_q};
    mcmd    = '0;
    mcmd.slot = slot_q;
    mcmd.toy  = toy_q;
    mcmd.keep = keep_q;
    case (kind_q)
      KIND_READY: begin
        emit = 1'b1;
        rk   = RESP_READY;
        b1   = RDY_B1;
        b2   = RDY_B2;
      end
      KIND_ACTIVATE: begin
        emit            = 1'b1;
        rk              = RESP_ACTIVATE;
        b1              = {7'd0, act_new};
        b2              = ACT_B2;
        plo             = 64'(ACT_PLO);
        mcmd.set_active = 1'b1;
        mcmd.active_val = act_new;
      end
      KIND_COLOR: begin
        emit = 1'b1;
        rk   = RESP_COLOR;
        b1   = ba_q;
        b2   = bb_q;
        plo  = 64'(bc_q);
      end
      KIND_QUERY: begin
        emit = 1'b1;
        rk   = RESP_QUERY;
        b2   = block_q;
        if (hit) begin
          b1  = QRY_HIT + {4'd0, slot_q};
          plo = mem_rdata_i[63:0];
          phi = mem_rdata_i[127:64];
        end else begin
          b1 = QRY_ERR;
        end
      end
      KIND_WRITE: begin
        emit  = 1'b1;
        rk    = RESP_WRITE;
        b2    = block_q;
        wr_en = addr_ok_q;
      end
      KIND_STATUS_TICK: begin
        emit           = meta_stat_i.active;
        rk             = RESP_STATUS;
        b1             = packed_bits[7:0];
        b2             = packed_bits[15:8];
        plo            = {32'd0, STS_MARK, meta_stat_i.count, packed_bits[31:16]};
        mcmd.count_inc = meta_stat_i.active;
      end
      KIND_SET_PRESENT: begin
        wr_en        = addr_ok_q;
        wr_data      = {mem_rdata_i[127:16], toy_q};
        mcmd.set_toy = slot_ok_q;
      end
      KIND_LOAD_BLOCK: begin
        wr_en     = addr_ok_q;
        mcmd.mark = addr_ok_q;
      end
      KIND_CLEAR: begin
        mcmd.drop = slot_ok_q;
      end
      KIND_SYNC: begin
        mcmd.sync = 1'b1;
      end
      KIND_READ_STATE: begin
        emit = 1'b1;
        rk   = RESP_STATE;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = addr_q;
    mem_wdata_o = wr_data;
    meta_cmd_o  = '0;
    case (state_q)
      ST_CLEAR: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = clr_q;
        mem_wdata_o = '0;
        clr_d       = clr_q + 1'b1;
        if (clr_q == LAST_ADDR) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        mem_we_o   = wr_en;
        meta_cmd_o = mcmd;
        state_d    = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      done_q  <= (state_q == ST_EXEC) && emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == ST_EXEC) && emit) begin
      rk_q  <= rk;
      b1_q  <= b1;
      b2_q  <= b2;
      plo_q <= plo;
      phi_q <= phi;
    end
  end

  assign busy         = (state_q != ST_IDLE);
  assign done_o       = done_q;
  assign resp_kind_o  = rk_q;
  assign byte1_o      = b1_q;
  assign byte2_o      = b2_q;
  assign payload_lo_o = plo_q;
  assign payload_hi_o = phi_q;

endmodule

`default_nettype wire

[rtl/figure_portal_slot_store.sv]
// An item accepted at one edge is executed in the next cycle; its report
// strobes done_o in the cycle after that. A new item is taken only while
// idle, not before the last one's block read (registered port) and write-back.
// Reset: toy ids, present mask, flag and counter clear at once; the block memory is
// zeroed by one pass over its SLOTS*BLOCKS words (1024 by default), busy high.
// Reports last one cycle and cannot be stalled by the receiver.
`default_nettype none

module figure_portal_slot_store #(
  parameter int unsigned SLOTS     = fps_pkg::DEF_SLOTS,
  parameter int unsigned BLOCKS    = fps_pkg::DEF_BLOCKS,
  parameter int unsigned TOY_BLOCK = fps_pkg::DEF_TOY_BLOCK
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [3:0]  kind_i,
  input  wire logic [3:0]  slot_i,
  input  wire logic [7:0]  block_i,
  input  wire logic [7:0]  byte_a_i,
  input  wire logic [7:0]  byte_b_i,
  input  wire logic [7:0]  byte_c_i,
  input  wire logic        arg_present_i,
  input  wire logic [63:0] data_lo_i,
  input  wire logic [63:0] data_hi_i,
  input  wire logic [15:0] toy_id_i,
  input  wire logic [15:0] keep_mask_i,
  output logic             done_o,
  output logic [2:0]       resp_kind_o,
  output logic [7:0]       byte1_o,
  output logic [7:0]       byte2_o,
  output logic [63:0]      payload_lo_o,
  output logic [63:0]      payload_hi_o,
  output logic             activated_o,
  output logic [15:0]      current_toy_o
);
  import fps_pkg::*;

  localparam int unsigned DEPTH  = SLOTS * BLOCKS;
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;
  logic [BLK_W-1:0]  mem_wdata, mem_rdata;
  meta_cmd_t         meta_cmd;
  meta_stat_t        meta_stat;

  fps_mem #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  fps_meta u_meta (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (meta_cmd),
    .stat_o (meta_stat)
  );

  fps_ctrl #(
    .SLOTS     (SLOTS),
    .BLOCKS    (BLOCKS),
    .TOY_BLOCK (TOY_BLOCK),
    .DEPTH     (DEPTH),
    .ADDR_W    (ADDR_W)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .kind_i        (kind_i),
    .slot_i        (slot_i),
    .block_i       (block_i),
    .byte_a_i      (byte_a_i),
    .byte_b_i      (byte_b_i),
    .byte_c_i      (byte_c_i),
    .arg_present_i (arg_present_i),
    .data_lo_i     (data_lo_i),
    .data_hi_i     (data_hi_i),
    .toy_id_i      (toy_id_i),
    .keep_mask_i   (keep_mask_i),
    .done_o        (done_o),
    .resp_kind_o   (resp_kind_o),
    .byte1_o       (byte1_o),
    .byte2_o       (byte2_o),
    .payload_lo_o  (payload_lo_o),
    .payload_hi_o  (payload_hi_o),
    .mem_we_o      (mem_we),
    .mem_waddr_o   (mem_waddr),
    .mem_wdata_o   (mem_wdata),
    .mem_re_o      (mem_re),
    .mem_raddr_o   (mem_raddr),
    .mem_rdata_i   (mem_rdata),
    .meta_cmd_o    (meta_cmd),
    .meta_stat_i   (meta_stat)
  );

  assign activated_o   = meta_stat.active;
  assign current_toy_o = meta_stat.current_toy;

`ifndef SYNTH
  a_accept_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not occupy the block");

  a_done_after_exec : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy))
    else $error("report without an executing transaction");

  a_done_single : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("back-to-back reports");
`endif

endmodule

`default_nettype wire
